// ===== design/assert_macros.svh =====
// Assertion macros shared by the ray caster modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/grc_pkg.sv =====
// Types, constants and codes shared by the grid ray caster.
package grc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAP_DIM      = 32;
    localparam int SCREEN_WIDTH = 1024;
    localparam int SCREEN_SHIFT = $clog2(SCREEN_WIDTH);

    localparam int CELL_W  = 5;
    localparam int ADDR_W  = 2 * CELL_W;
    localparam int VAL_W   = 8;
    localparam int COL_W   = 10;
    localparam int POS_W   = 21;
    localparam int VEC_W   = 24;
    localparam int SCALE_W = 16;
    localparam int CAM_W   = FRAC_BITS + 2;
    localparam int PROD_W  = VEC_W + CAM_W;
    localparam int RAY_W   = FRAC_BITS + 9;
    localparam int DIST_W  = 24;
    localparam int HGT_W   = 16;
    localparam int DIV_W   = 40;
    localparam int DVS_W   = RAY_W;
    localparam int SUM_W   = 32;
    localparam int MC_W    = CELL_W + 2;
    localparam int STEP_LIMIT = 2 * MAP_DIM + 2;
    localparam int STEP_W  = $clog2(STEP_LIMIT + 1);
    localparam int Q_DEPTH = 2;
    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_POS_X      = 3'd0,
        REG_POS_Y      = 3'd1,
        REG_DIR_X      = 3'd2,
        REG_DIR_Y      = 3'd3,
        REG_PLANE_X    = 3'd4,
        REG_PLANE_Y    = 3'd5,
        REG_WALL_SCALE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        op_t               op;
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [VEC_W-1:0]   dir_x;
        logic [VEC_W-1:0]   dir_y;
        logic [VEC_W-1:0]   plane_x;
        logic [VEC_W-1:0]   plane_y;
        logic [SCALE_W-1:0] wall_scale;
    } cam_cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] hit_x;
        logic [CELL_W-1:0] hit_y;
        logic              side;
        logic [DIST_W-1:0] perp_dist;
        logic [HGT_W-1:0]  height;
        logic              escaped;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CAM, S_RAY, S_DXS, S_DXW, S_DYS, S_DYW, S_SXI,
        S_SYI, S_STEP, S_CHECK, S_PS, S_PW, S_HS, S_HW, S_FIN
    } back_state_t;

endpackage

// ===== design/grid_raycast_dda.sv =====
// Top level of the grid ray caster: config registers, front queue and back engine.
//
// Write words (func 0) store one 8-bit map cell; cast words (func 1) build the camera
// ray for a screen column, walk a 32x32 grid with a DDA until a nonzero cell, the map
// edge or the step bound, and return one result word: hit cell, side, perpendicular
// distance (Q8.16, saturating), wall height = wall_scale / distance (saturating) and an
// escaped flag. Words enter a small queue in the front end and are executed strictly in
// order by the back end, so a cast always sees exactly the map writes that came before
// it. A cast runs four divides (two step distances, the distance and the height) in the
// shared one-bit-per-cycle divider, and each DDA step does one registered map read; the
// walk is bounded at 66 steps. An escaped ray skips the last two divides. The final
// state holds while the previous result word still waits for the consumer. One result
// word is held for the consumer while the back end already works on the next words.
// Map cells that were never written read back undefined. Configuration must be written
// only while the block is idle; the block does not enforce this, and cfg_ready is
// always high.
module grid_raycast_dda
    import grc_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              func,
    input  logic [COL_W-1:0]  column,
    input  logic [CELL_W-1:0] cell_x,
    input  logic [CELL_W-1:0] cell_y,
    input  logic [VAL_W-1:0]  cell_value,
    output logic              empty,
    input  logic              pop,
    output logic [COL_W-1:0]  out_column,
    output logic [CELL_W-1:0] hit_x,
    output logic [CELL_W-1:0] hit_y,
    output logic              side,
    output logic [DIST_W-1:0] perp_dist,
    output logic [HGT_W-1:0]  height,
    output logic              escaped,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [VEC_W-1:0]  cfg_data
);

    cam_cfg_t cfg_reg;
    logic     q_pop, q_empty, res_valid, res_pop;
    item_t    q_item;
    result_t  res;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x      <= POS_W'(1441792);
            cfg_reg.pos_y      <= POS_W'(786432);
            cfg_reg.dir_x      <= VEC_W'(-65536);
            cfg_reg.dir_y      <= '0;
            cfg_reg.plane_x    <= '0;
            cfg_reg.plane_y    <= VEC_W'(43253);
            cfg_reg.wall_scale <= SCALE_W'(64);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POS_X:      cfg_reg.pos_x      <= cfg_data[POS_W-1:0];
                REG_POS_Y:      cfg_reg.pos_y      <= cfg_data[POS_W-1:0];
                REG_DIR_X:      cfg_reg.dir_x      <= cfg_data;
                REG_DIR_Y:      cfg_reg.dir_y      <= cfg_data;
                REG_PLANE_X:    cfg_reg.plane_x    <= cfg_data;
                REG_PLANE_Y:    cfg_reg.plane_y    <= cfg_data;
                REG_WALL_SCALE: cfg_reg.wall_scale <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    grc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .column     (column),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_value (cell_value),
        .q_pop      (q_pop),
        .q_empty    (q_empty),
        .q_item     (q_item)
    );

    assign res_pop = pop && res_valid;

    grc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_pop   (res_pop),
        .res       (res)
    );

    assign empty      = !res_valid;
    assign out_column = res.column;
    assign hit_x      = res.hit_x;
    assign hit_y      = res.hit_y;
    assign side       = res.side;
    assign perp_dist  = res.perp_dist;
    assign height     = res.height;
    assign escaped    = res.escaped;

endmodule

// ===== design/grc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/grc_div.sv =====
// Restoring divider, one quotient bit per cycle; zero divisor gives all ones.
module grc_div
    import grc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [DVS_W:0]   rem_sh, diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/grc_front.sv =====
// Front end: takes input words, classifies them and queues them for the back end.
`include "assert_macros.svh"
module grc_front
    import grc_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              func,
    input  logic [COL_W-1:0]  column,
    input  logic [CELL_W-1:0] cell_x,
    input  logic [CELL_W-1:0] cell_y,
    input  logic [VAL_W-1:0]  cell_value,
    input  logic              q_pop,
    output logic              q_empty,
    output item_t             q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;
    item_t            in_item;

    always_comb
    begin
        in_item.op     = func ? OP_CAST : OP_WRITE;
        in_item.column = column;
        in_item.cell_x = cell_x;
        in_item.cell_y = cell_y;
        in_item.value  = cell_value;
    end

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;
    assign q_item  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= in_item;
        end
    end

    // pointers wrap on their own only when depth is a power of two; the block does not check this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_fill_tracks, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

// ===== design/grc_back.sv =====
// Back end: applies map writes and runs the ray setup, DDA walk and divides.
`include "assert_macros.svh"
module grc_back
    import grc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cam_cfg_t cfg,
    input  logic     q_empty,
    input  item_t    q_item,
    output logic     q_pop,
    output logic     res_valid,
    input  logic     res_pop,
    output result_t  res
);

    localparam logic signed [PROD_W-1:0] RAY_HI = PROD_W'((64'sd1 <<< (FRAC_BITS + 8)) - 1);
    localparam logic signed [PROD_W-1:0] RAY_LO = -PROD_W'(64'sd1 <<< (FRAC_BITS + 8));
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [HGT_W-1:0]  HGT_MAX  = '1;
    localparam logic signed [CAM_W-1:0] ONE_CAM = CAM_W'(1 << FRAC_BITS);

    back_state_t state_reg, state_next;

    // control
    logic ram_we, div_start, res_load, div_busy, div_done;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [DVS_W-1:0] div_divisor;
    logic [VAL_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] ram_raddr;

    // datapath registers
    logic [COL_W-1:0]         col_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [RAY_W-1:0]  rdx_reg, rdy_reg;
    logic signed [MC_W-1:0]   mx_reg, my_reg;
    logic [FRAC_BITS-1:0]     fx_reg, fy_reg;
    logic [DIST_W-1:0]        dx_reg, dy_reg, dist_reg;
    logic [SUM_W-1:0]         sx_reg, sy_reg;
    logic [STEP_W-1:0]        n_reg;
    logic                     side_reg, hit_reg;
    logic [HGT_W-1:0]         hgt_reg;
    logic                     res_valid_reg;
    result_t                  res_reg;

    // combinational helpers
    logic signed [CAM_W-1:0]  cam_s;
    logic [COL_W+FRAC_BITS:0] cam_num;
    logic                     step_x, new_in_map, start_in_map;
    logic signed [MC_W-1:0]   mx_new, my_new;
    logic [DVS_W-1:0]         abs_rdx, abs_rdy;
    logic [FRAC_BITS:0]       fsel_x, fsel_y;
    logic [FRAC_BITS+DIST_W:0] side_prod_x, side_prod_y;
    logic signed [MC_W+FRAC_BITS:0] edge_v, num_s;
    logic [MC_W+FRAC_BITS:0]  num_abs;
    logic [DIST_W-1:0]        q_sat24;
    logic                     res_blank;

    function automatic logic signed [RAY_W-1:0] clamp_ray(
        input logic signed [VEC_W-1:0] dir_v,
        input logic signed [PROD_W-1:0] prod_v
    );
        logic signed [PROD_W-1:0] sum_v;
        sum_v = PROD_W'(dir_v) + (prod_v >>> FRAC_BITS);
        if (sum_v > RAY_HI)
        begin
            return RAY_HI[RAY_W-1:0];
        end
        else if (sum_v < RAY_LO)
        begin
            return RAY_LO[RAY_W-1:0];
        end
        return sum_v[RAY_W-1:0];
    endfunction

    function automatic logic in_map(input logic signed [MC_W-1:0] c);
        return (c >= 0) && (c < MC_W'(MAP_DIM));
    endfunction

    assign cam_num = {col_reg, {(FRAC_BITS + 1){1'b0}}};
    assign cam_s   = $signed(CAM_W'(cam_num >> SCREEN_SHIFT)) - ONE_CAM;

    assign abs_rdx = rdx_reg[RAY_W-1] ? DVS_W'(-rdx_reg) : DVS_W'(rdx_reg);
    assign abs_rdy = rdy_reg[RAY_W-1] ? DVS_W'(-rdy_reg) : DVS_W'(rdy_reg);

    assign fsel_x = rdx_reg[RAY_W-1] ? {1'b0, fx_reg} : (FRAC_BITS+1)'(1 << FRAC_BITS) - fx_reg;
    assign fsel_y = rdy_reg[RAY_W-1] ? {1'b0, fy_reg} : (FRAC_BITS+1)'(1 << FRAC_BITS) - fy_reg;
    assign side_prod_x = fsel_x * dx_reg;
    assign side_prod_y = fsel_y * dy_reg;

    // DDA step: the smaller side distance advances, ties go along y
    assign step_x = (sx_reg < sy_reg);
    assign mx_new = step_x ? (rdx_reg[RAY_W-1] ? mx_reg - 1'b1 : mx_reg + 1'b1) : mx_reg;
    assign my_new = step_x ? my_reg : (rdy_reg[RAY_W-1] ? my_reg - 1'b1 : my_reg + 1'b1);
    assign new_in_map   = in_map(mx_new) && in_map(my_new);
    assign start_in_map = in_map(mx_reg) && in_map(my_reg);
    assign ram_raddr    = {mx_new[CELL_W-1:0], my_new[CELL_W-1:0]};

    // distance from the viewer to the crossed cell edge
    always_comb
    begin
        if (!side_reg)
        begin
            edge_v = ((MC_W+FRAC_BITS+1)'(mx_reg) + (rdx_reg[RAY_W-1] ? 1'b1 : 1'b0))
                     <<< FRAC_BITS;
            num_s  = edge_v - $signed({1'b0, (MC_W+FRAC_BITS)'(cfg.pos_x)});
        end
        else
        begin
            edge_v = ((MC_W+FRAC_BITS+1)'(my_reg) + (rdy_reg[RAY_W-1] ? 1'b1 : 1'b0))
                     <<< FRAC_BITS;
            num_s  = edge_v - $signed({1'b0, (MC_W+FRAC_BITS)'(cfg.pos_y)});
        end
        num_abs = num_s[MC_W+FRAC_BITS] ? (MC_W+FRAC_BITS+1)'(-num_s)
                                        : (MC_W+FRAC_BITS+1)'(num_s);
    end

    assign q_sat24 = (div_q > DIV_W'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_empty && q_item.op == OP_CAST) state_next = S_CAM;
            S_CAM:   state_next = S_RAY;
            S_RAY:   state_next = S_DXS;
            S_DXS:   state_next = S_DXW;
            S_DXW:   if (div_done) state_next = S_DYS;
            S_DYS:   state_next = S_DYW;
            S_DYW:   if (div_done) state_next = S_SXI;
            S_SXI:   state_next = S_SYI;
            S_SYI:   state_next = start_in_map ? S_STEP : S_FIN;
            S_STEP:  state_next = new_in_map ? S_CHECK : S_FIN;
            S_CHECK:
            begin
                if (ram_rdata != '0)
                begin
                    state_next = S_PS;
                end
                else if (n_reg == STEP_W'(STEP_LIMIT))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_PS:    state_next = S_PW;
            S_PW:    if (div_done) state_next = S_HS;
            S_HS:    state_next = S_HW;
            S_HW:    if (div_done) state_next = S_FIN;
            S_FIN:   if (!res_valid_reg || res_pop) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        res_load     = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_pop  = !q_empty;
                ram_we = !q_empty && (q_item.op == OP_WRITE);
            end
            S_DXS:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(1) << (2 * FRAC_BITS);
                div_divisor  = abs_rdx;
            end
            S_DYS:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(1) << (2 * FRAC_BITS);
                div_divisor  = abs_rdy;
            end
            S_PS:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(num_abs) << FRAC_BITS;
                div_divisor  = side_reg ? abs_rdy : abs_rdx;
            end
            S_HS:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(cfg.wall_scale) << FRAC_BITS;
                div_divisor  = DVS_W'(dist_reg);
            end
            S_FIN:   res_load = !res_valid_reg || res_pop;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                col_reg  <= q_item.column;
                hit_reg  <= 1'b0;
                side_reg <= 1'b0;
                dist_reg <= '0;
                hgt_reg  <= '0;
            end
            S_CAM:
            begin
                prod_x_reg <= $signed(cfg.plane_x) * cam_s;
                prod_y_reg <= $signed(cfg.plane_y) * cam_s;
            end
            S_RAY:
            begin
                rdx_reg <= clamp_ray($signed(cfg.dir_x), prod_x_reg);
                rdy_reg <= clamp_ray($signed(cfg.dir_y), prod_y_reg);
                mx_reg  <= $signed(MC_W'(cfg.pos_x[POS_W-1:FRAC_BITS]));
                my_reg  <= $signed(MC_W'(cfg.pos_y[POS_W-1:FRAC_BITS]));
                fx_reg  <= cfg.pos_x[FRAC_BITS-1:0];
                fy_reg  <= cfg.pos_y[FRAC_BITS-1:0];
                n_reg   <= '0;
            end
            S_DXW:   if (div_done) dx_reg <= q_sat24;
            S_DYW:   if (div_done) dy_reg <= q_sat24;
            S_SXI:   sx_reg <= SUM_W'(side_prod_x >> FRAC_BITS);
            S_SYI:   sy_reg <= SUM_W'(side_prod_y >> FRAC_BITS);
            S_STEP:
            begin
                mx_reg   <= mx_new;
                my_reg   <= my_new;
                side_reg <= !step_x;
                n_reg    <= n_reg + 1'b1;
                if (step_x)
                begin
                    sx_reg <= sx_reg + SUM_W'(dx_reg);
                end
                else
                begin
                    sy_reg <= sy_reg + SUM_W'(dy_reg);
                end
            end
            S_CHECK: if (ram_rdata != '0) hit_reg <= 1'b1;
            S_PW:    if (div_done) dist_reg <= q_sat24;
            S_HW:
            begin
                if (div_done)
                begin
                    hgt_reg <= (div_q > DIV_W'(HGT_MAX)) ? HGT_MAX : div_q[HGT_W-1:0];
                end
            end
            S_FIN:
            begin
                if (res_load)
                begin
                    res_reg.column    <= col_reg;
                    res_reg.hit_x     <= hit_reg ? mx_reg[CELL_W-1:0] : '0;
                    res_reg.hit_y     <= hit_reg ? my_reg[CELL_W-1:0] : '0;
                    res_reg.side      <= hit_reg & side_reg;
                    res_reg.perp_dist <= dist_reg;
                    res_reg.height    <= hgt_reg;
                    res_reg.escaped   <= !hit_reg;
                end
            end
            default: ;
        endcase
    end

    grc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({q_item.cell_x, q_item.cell_y}),
        .wdata (q_item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_blank = (res_reg.height == '0) && (res_reg.perp_dist == '0);

    `ASSERT_IMPL(a_pop_idle, q_pop, state_reg == S_IDLE)
    `ASSERT_IMPL(a_div_free, div_start, !div_busy)
    `ASSERT_IMPL(a_esc_zero, res_valid_reg && res_reg.escaped, res_blank)

endmodule
